// File: rtl/dnsrp_pkg.sv
package dnsrp_pkg;

  // Kinds of result transaction.
  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_QTYPE  = 3'd1;
  localparam logic [2:0] KIND_AHDR   = 3'd2;
  localparam logic [2:0] KIND_ADATA  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RCODE  = 3'd1;
  localparam logic [2:0] ST_QDCNT  = 3'd2;
  localparam logic [2:0] ST_PTR    = 3'd3;
  localparam logic [2:0] ST_NAME   = 3'd4;
  localparam logic [2:0] ST_TYPE   = 3'd5;
  localparam logic [2:0] ST_RDLONG = 3'd6;
  localparam logic [2:0] ST_TRUNC  = 3'd7;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;
  localparam logic [15:0] MAX_PLAIN_RDATA = 16'd16;
  localparam logic [7:0]  DOT_CHAR = 8'h2E;
  localparam int unsigned HEADER_BYTES = 12;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] record_type;
    logic [31:0] ttl;
    logic [15:0] data_length;
    logic [2:0]  answer_index;
    logic [3:0]  response_code;
    logic [15:0] answer_total;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // What one byte produces: up to two results.
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } pair_t;

endpackage

// File: rtl/dns_response_parser.sv
// DNS response parser: takes one message byte per transaction and, at one
// byte per cycle while the result queue has room, emits the question name
// characters, the question type, answer headers, answer data bytes and a
// final status transaction. A four-entry result queue decouples the parser
// front end from the output, so input stalls only when fewer than two queue
// slots are free. Results are written into the queue as their byte is taken.
module dns_response_parser import dnsrp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 512,
  parameter int unsigned MAX_NAME_BYTES    = 256,
  parameter int unsigned MAX_LABELS        = 32,
  parameter int unsigned MAX_ANSWER_SLOTS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  byte_value_o,
  output logic [15:0] record_type_o,
  output logic [31:0] time_to_live_o,
  output logic [15:0] data_length_o,
  output logic [2:0]  answer_index_o,
  output logic [3:0]  response_code_o,
  output logic [15:0] answer_total_o,
  output logic [2:0]  parse_status_o,
  output logic        last_result_o
);

  pair_t   pair;
  result_t res;
  logic    take;

  assign take = in_valid_i && in_ready_o;

  dnsrp_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES), .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .MAX_LABELS(MAX_LABELS), .MAX_ANSWER_SLOTS(MAX_ANSWER_SLOTS)
  ) u_front (
    .clk_i, .rst_ni, .take_i(take), .byte_i(payload_byte_i),
    .end_i(message_end_i), .pair_o(pair)
  );

  dnsrp_queue u_queue (
    .clk_i, .rst_ni, .pair_i(pair), .push_i(take), .space_o(in_ready_o),
    .valid_o(out_valid_o), .res_o(res), .ready_i(out_ready_i)
  );

  assign result_kind_o   = res.kind;
  assign byte_value_o    = res.byte_value;
  assign record_type_o   = res.record_type;
  assign time_to_live_o  = res.ttl;
  assign data_length_o   = res.data_length;
  assign answer_index_o  = res.answer_index;
  assign response_code_o = res.response_code;
  assign answer_total_o  = res.answer_total;
  assign parse_status_o  = res.status;
  assign last_result_o   = res.last;

endmodule

// File: rtl/dnsrp_front.sv
module dnsrp_front import dnsrp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 512,
  parameter int unsigned MAX_NAME_BYTES    = 256,
  parameter int unsigned MAX_LABELS        = 32,
  parameter int unsigned MAX_ANSWER_SLOTS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output pair_t      pair_o
);

  typedef enum logic [20:0] {
    PH_HDR  = 21'd1 << 0,  PH_NLEN = 21'd1 << 1,  PH_NCHR = 21'd1 << 2,
    PH_QT0  = 21'd1 << 3,  PH_QT1  = 21'd1 << 4,  PH_QC0  = 21'd1 << 5,
    PH_QC1  = 21'd1 << 6,  PH_PTR0 = 21'd1 << 7,  PH_PTR1 = 21'd1 << 8,
    PH_AT0  = 21'd1 << 9,  PH_AT1  = 21'd1 << 10, PH_AC0  = 21'd1 << 11,
    PH_AC1  = 21'd1 << 12, PH_TTL0 = 21'd1 << 13, PH_TTL1 = 21'd1 << 14,
    PH_TTL2 = 21'd1 << 15, PH_TTL3 = 21'd1 << 16, PH_LEN0 = 21'd1 << 17,
    PH_LEN1 = 21'd1 << 18, PH_DATA = 21'd1 << 19, PH_DONE = 21'd1 << 20
  } phase_e;

  localparam int unsigned PosW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned NlW  = $clog2(MAX_NAME_BYTES + 64);
  localparam int unsigned LnW  = $clog2(MAX_LABELS + 1);
  localparam int unsigned AnW  = $clog2(MAX_ANSWER_SLOTS);

  phase_e        phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]   flags_q, flags_d, qd_q, qd_d, an_q, an_d;
  logic [7:0]    lrem_q, lrem_d;
  logic [NlW-1:0] nlen_q, nlen_d;
  logic [LnW-1:0] lnum_q, lnum_d;
  logic [31:0]   acc_q, acc_d;
  logic [15:0]   ctype_q, ctype_d, drem_q, drem_d;
  logic [AnW-1:0] anum_q, anum_d;
  logic          done_q, done_d;

  logic [15:0] t16, dlen;
  logic        fin;
  logic [2:0]  fin_st;
  result_t     blank, stat;
  logic [AnW-1:0] anum_nx;
  logic        more;

  always_comb begin
    blank = '0;
    t16   = {acc_q[7:0], byte_i};
    dlen  = {drem_q[15:8], byte_i};
    phase_d = phase_q; pos_d = pos_q; flags_d = flags_q; qd_d = qd_q; an_d = an_q;
    lrem_d = lrem_q; nlen_d = nlen_q; lnum_d = lnum_q; acc_d = acc_q;
    ctype_d = ctype_q; drem_d = drem_q; anum_d = anum_q; done_d = done_q;
    fin = 1'b0; fin_st = ST_OK;
    pair_o = '0;
    anum_nx = anum_q + AnW'(1);
    more = 1'b0;

    if (!done_q) begin
      if (pos_q >= PosW'(MAX_PAYLOAD_BYTES)) begin
        fin = 1'b1; fin_st = ST_TRUNC;
      end else begin
        pos_d = pos_q + PosW'(1);
        case (phase_q)
          PH_HDR: begin
            if (pos_q == PosW'(2)) flags_d[15:8] = byte_i;
            if (pos_q == PosW'(3)) flags_d[7:0] = byte_i;
            if (pos_q == PosW'(4)) qd_d[15:8] = byte_i;
            if (pos_q == PosW'(5)) qd_d[7:0] = byte_i;
            if (pos_q == PosW'(6)) an_d[15:8] = byte_i;
            if (pos_q == PosW'(7)) an_d[7:0] = byte_i;
            if (pos_q == PosW'(HEADER_BYTES - 1)) begin
              if (flags_q[3:0] != 4'd0) begin fin = 1'b1; fin_st = ST_RCODE; end
              else if (qd_q != 16'd1) begin fin = 1'b1; fin_st = ST_QDCNT; end
              else phase_d = PH_NLEN;
            end
          end
          PH_NLEN: begin
            if (byte_i == 8'd0) begin
              if (lnum_q == '0) begin fin = 1'b1; fin_st = ST_NAME; end
              else phase_d = PH_QT0;
            end else if (byte_i[7:6] == 2'b11) begin
              fin = 1'b1; fin_st = ST_PTR;
            end else if (byte_i > 8'd63 || lnum_q >= LnW'(MAX_LABELS) ||
                         ({1'b0, nlen_q} + (NlW+1)'(byte_i)) >=
                         (NlW+1)'(MAX_NAME_BYTES)) begin
              fin = 1'b1; fin_st = ST_NAME;
            end else begin
              if (lnum_q != '0) begin
                pair_o.v0 = 1'b1;
                pair_o.r0 = blank;
                pair_o.r0.kind = KIND_CHAR;
                pair_o.r0.byte_value = DOT_CHAR;
              end
              lrem_d = byte_i;
              lnum_d = lnum_q + LnW'(1);
              nlen_d = nlen_q + NlW'(byte_i) + NlW'(1);
              phase_d = PH_NCHR;
            end
          end
          PH_NCHR: begin
            pair_o.v0 = 1'b1;
            pair_o.r0 = blank;
            pair_o.r0.kind = KIND_CHAR;
            pair_o.r0.byte_value = byte_i;
            lrem_d = lrem_q - 8'd1;
            if (lrem_q == 8'd1) phase_d = PH_NLEN;
          end
          PH_QT0: begin acc_d = {24'd0, byte_i}; phase_d = PH_QT1; end
          PH_AT0: begin acc_d = {24'd0, byte_i}; phase_d = PH_AT1; end
          PH_QT1, PH_AT1: begin
            if (t16 != TYPE_A && t16 != TYPE_AAAA && t16 != TYPE_CNAME) begin
              fin = 1'b1; fin_st = ST_TYPE;
            end else begin
              ctype_d = t16;
              if (phase_q == PH_QT1) begin
                pair_o.v0 = 1'b1;
                pair_o.r0 = blank;
                pair_o.r0.kind = KIND_QTYPE;
                pair_o.r0.record_type = t16;
                phase_d = PH_QC0;
              end else phase_d = PH_AC0;
            end
          end
          PH_QC0:  phase_d = PH_QC1;
          PH_QC1:  more = 1'b1;
          PH_PTR0: phase_d = PH_PTR1;
          PH_PTR1: phase_d = PH_AT0;
          PH_AC0:  phase_d = PH_AC1;
          PH_AC1:  phase_d = PH_TTL0;
          PH_TTL0: begin acc_d = {24'd0, byte_i}; phase_d = PH_TTL1; end
          PH_TTL1: begin acc_d = {acc_q[23:0], byte_i}; phase_d = PH_TTL2; end
          PH_TTL2: begin acc_d = {acc_q[23:0], byte_i}; phase_d = PH_TTL3; end
          PH_TTL3: begin acc_d = {acc_q[23:0], byte_i}; phase_d = PH_LEN0; end
          PH_LEN0: begin drem_d = {byte_i, 8'd0}; phase_d = PH_LEN1; end
          PH_LEN1: begin
            drem_d = dlen;
            if ((ctype_q == TYPE_CNAME) ? (dlen >= 16'(MAX_NAME_BYTES))
                                        : (dlen > MAX_PLAIN_RDATA)) begin
              fin = 1'b1; fin_st = ST_RDLONG;
            end else begin
              pair_o.v0 = 1'b1;
              pair_o.r0 = blank;
              pair_o.r0.kind = KIND_AHDR;
              pair_o.r0.record_type = ctype_q;
              pair_o.r0.ttl = acc_q;
              pair_o.r0.data_length = dlen;
              pair_o.r0.answer_index = 3'(anum_q);
              if (dlen == 16'd0) begin
                anum_d = anum_nx; more = 1'b1;
              end else phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            pair_o.v0 = 1'b1;
            pair_o.r0 = blank;
            pair_o.r0.kind = KIND_ADATA;
            pair_o.r0.byte_value = byte_i;
            pair_o.r0.answer_index = 3'(anum_q);
            drem_d = drem_q - 16'd1;
            if (drem_q == 16'd1) begin anum_d = anum_nx; more = 1'b1; end
          end
          default: ;
        endcase
        // Move on to the next answer or close the message.
        if (more) begin
          if ({1'b0, anum_d} >= (AnW+1)'(MAX_ANSWER_SLOTS - 1) ||
              16'(anum_d) >= an_q) begin
            fin = 1'b1; fin_st = ST_OK;
          end else phase_d = PH_PTR0;
        end
      end
    end
    if (end_i && !done_q && !fin) begin
      fin = 1'b1; fin_st = ST_TRUNC;
    end

    // Status transaction goes after any data result of the same byte.
    stat = blank;
    stat.kind = KIND_STATUS;
    stat.response_code = flags_d[3:0];
    stat.answer_total = an_d;
    stat.status = fin_st;
    stat.last = 1'b1;
    if (fin) begin
      done_d = 1'b1; phase_d = PH_DONE;
      if (pair_o.v0) begin pair_o.v1 = 1'b1; pair_o.r1 = stat; end
      else begin pair_o.v0 = 1'b1; pair_o.r0 = stat; end
    end
    if (end_i) begin
      phase_d = PH_HDR; pos_d = '0; flags_d = '0; qd_d = '0; an_d = '0;
      lrem_d = '0; nlen_d = '0; lnum_d = '0; acc_d = '0; ctype_d = '0;
      drem_d = '0; anum_d = '0; done_d = 1'b0;
    end
    if (!take_i) pair_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; pos_q <= '0; flags_q <= '0; qd_q <= '0; an_q <= '0;
      lrem_q <= '0; nlen_q <= '0; lnum_q <= '0; acc_q <= '0; ctype_q <= '0;
      drem_q <= '0; anum_q <= '0; done_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d; pos_q <= pos_d; flags_q <= flags_d; qd_q <= qd_d;
      an_q <= an_d; lrem_q <= lrem_d; nlen_q <= nlen_d; lnum_q <= lnum_d;
      acc_q <= acc_d; ctype_q <= ctype_d; drem_q <= drem_d; anum_q <= anum_d;
      done_q <= done_d;
    end
  end

endmodule

// File: rtl/dnsrp_queue.sv
module dnsrp_queue import dnsrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pair_t   pair_i,
  input  logic    push_i,
  output logic    space_o,
  output logic    valid_o,
  output result_t res_o,
  input  logic    ready_i
);

  // Four-entry queue of results; a byte pushes up to two of them.
  result_t    mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] n_in;
  logic       pop;

  assign valid_o = cnt_q != 3'd0;
  assign res_o   = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  assign space_o = cnt_q <= 3'd2;
  assign n_in    = push_i ? (2'(pair_i.v0) + 2'(pair_i.v1)) : 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i && pair_i.v0) mem_q[wp_q] <= pair_i.r0;
    if (push_i && pair_i.v1) mem_q[wp_q + 2'd1] <= pair_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_in;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(n_in) - 3'(pop);
    end
  end

endmodule

// File: sim/dns_response_parser_test.sv
module dns_response_parser_test;
  import dnsrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAYLOAD_LIMIT = 512;
  localparam int unsigned NAME_LIMIT    = 256;
  localparam int unsigned LABEL_LIMIT   = 32;
  localparam int unsigned ANSWER_SLOTS  = 8;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned ITEM_TARGET   = 1150;

  // Parser phases of the predictor.
  typedef enum logic [4:0] {
    PH_HDR, PH_NLEN, PH_NCHR, PH_QT0, PH_QT1, PH_QC0, PH_QC1, PH_PTR0, PH_PTR1,
    PH_AT0, PH_AT1, PH_AC0, PH_AC1, PH_TTL0, PH_TTL1, PH_TTL2, PH_TTL3,
    PH_LEN0, PH_LEN1, PH_DATA, PH_DONE
  } phase_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  // Status expected of one directed message, where it is known outright.
  typedef struct {
    bit         known;
    logic [2:0] status;
  } status_check_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  payload_byte_i = '0;
  logic        message_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [7:0]  byte_value_o;
  logic [15:0] record_type_o;
  logic [31:0] time_to_live_o;
  logic [15:0] data_length_o;
  logic [2:0]  answer_index_o;
  logic [3:0]  response_code_o;
  logic [15:0] answer_total_o;
  logic [2:0]  parse_status_o;
  logic        last_result_o;

  dns_response_parser i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  phase_e      pr_phase;
  logic [15:0] pr_pos;
  logic [15:0] pr_flags, pr_qdcount, pr_ancount;
  logic [7:0]  pr_label_left;
  logic [15:0] pr_name_len;
  logic [7:0]  pr_labels;
  logic [31:0] pr_acc;
  logic [15:0] pr_type, pr_data_left;
  logic [7:0]  pr_answer;
  logic        pr_done;

  result_t     expected_results[$];
  msg_byte_t   byte_stream[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          rx_hold = 1'b0;
  bit          quiet_spell = 1'b0;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void clear_parser();
    pr_phase = PH_HDR; pr_pos = '0; pr_flags = '0; pr_qdcount = '0; pr_ancount = '0;
    pr_label_left = '0; pr_name_len = '0; pr_labels = '0; pr_acc = '0;
    pr_type = '0; pr_data_left = '0; pr_answer = '0; pr_done = 1'b0;
  endfunction

  function automatic void push_result(logic [2:0] kind, logic [7:0] bv, logic [15:0] rt,
                                      logic [31:0] ttl, logic [15:0] len, logic [2:0] idx,
                                      logic [3:0] rc, logic [15:0] tot, logic [2:0] st,
                                      logic last);
    result_t r;
    r.kind = kind; r.byte_value = bv; r.record_type = rt; r.ttl = ttl;
    r.data_length = len; r.answer_index = idx; r.response_code = rc;
    r.answer_total = tot; r.status = st; r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void close_message(logic [2:0] st);
    push_result(KIND_STATUS, 0, 0, 0, 0, 0, pr_flags[3:0], pr_ancount, st, 1'b1);
    pr_done = 1'b1;
    pr_phase = PH_DONE;
  endfunction

  function automatic bit known_type(logic [15:0] t);
    return t == TYPE_A || t == TYPE_AAAA || t == TYPE_CNAME;
  endfunction

  function automatic void advance_answer();
    if (pr_answer >= ANSWER_SLOTS - 1 || pr_answer >= pr_ancount) close_message(ST_OK);
    else pr_phase = PH_PTR0;
  endfunction

  // Works out the results of one accepted message byte.
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [15:0] t;
    if (!pr_done) begin
      if (pr_pos >= PAYLOAD_LIMIT) begin
        close_message(ST_TRUNC);
      end else begin
        case (pr_phase)
          PH_HDR: begin
            case (pr_pos)
              2: pr_flags[15:8] = b;
              3: pr_flags[7:0] = b;
              4: pr_qdcount[15:8] = b;
              5: pr_qdcount[7:0] = b;
              6: pr_ancount[15:8] = b;
              7: pr_ancount[7:0] = b;
              default: ;
            endcase
            if (pr_pos == HEADER_BYTES - 1) begin
              if (pr_flags[3:0] != 0) close_message(ST_RCODE);
              else if (pr_qdcount != 1) close_message(ST_QDCNT);
              else pr_phase = PH_NLEN;
            end
          end
          PH_NLEN: begin
            if (b == 0) begin
              if (pr_labels == 0) close_message(ST_NAME);
              else pr_phase = PH_QT0;
            end else if (b[7:6] == 2'b11) begin
              close_message(ST_PTR);
            end else if (b > 63 || pr_labels >= LABEL_LIMIT ||
                         int'(pr_name_len) + int'(b) >= NAME_LIMIT) begin
              close_message(ST_NAME);
            end else begin
              if (pr_labels > 0) push_result(KIND_CHAR, DOT_CHAR, 0, 0, 0, 0, 0, 0, 0, 0);
              pr_label_left = b;
              pr_labels++;
              pr_name_len = pr_name_len + b + 1;
              pr_phase = PH_NCHR;
            end
          end
          PH_NCHR: begin
            push_result(KIND_CHAR, b, 0, 0, 0, 0, 0, 0, 0, 0);
            pr_label_left--;
            if (pr_label_left == 0) pr_phase = PH_NLEN;
          end
          PH_QT0, PH_AT0, PH_TTL0: begin
            pr_acc = {24'd0, b};
            pr_phase = phase_e'(pr_phase + 1);
          end
          PH_QT1, PH_AT1: begin
            t = {pr_acc[7:0], b};
            if (!known_type(t)) begin
              close_message(ST_TYPE);
            end else begin
              pr_type = t;
              if (pr_phase == PH_QT1) push_result(KIND_QTYPE, 0, t, 0, 0, 0, 0, 0, 0, 0);
              pr_phase = phase_e'(pr_phase + 1);
            end
          end
          PH_QC1: advance_answer();
          PH_TTL1, PH_TTL2, PH_TTL3: begin
            pr_acc = {pr_acc[23:0], b};
            pr_phase = phase_e'(pr_phase + 1);
          end
          PH_LEN0: begin
            pr_data_left = {b, 8'd0};
            pr_phase = PH_LEN1;
          end
          PH_LEN1: begin
            pr_data_left[7:0] = b;
            if (pr_type == TYPE_CNAME ? pr_data_left >= NAME_LIMIT
                                      : pr_data_left > MAX_PLAIN_RDATA) begin
              close_message(ST_RDLONG);
            end else begin
              push_result(KIND_AHDR, 0, pr_type, pr_acc, pr_data_left, pr_answer[2:0],
                          0, 0, 0, 0);
              if (pr_data_left == 0) begin
                pr_answer++;
                advance_answer();
              end else begin
                pr_phase = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            push_result(KIND_ADATA, b, 0, 0, 0, pr_answer[2:0], 0, 0, 0, 0);
            pr_data_left--;
            if (pr_data_left == 0) begin
              pr_answer++;
              advance_answer();
            end
          end
          PH_QC0, PH_PTR0, PH_PTR1, PH_AC0, PH_AC1: pr_phase = phase_e'(pr_phase + 1);
          default: ;
        endcase
        pr_pos++;
      end
    end
    if (last) begin
      if (!pr_done) close_message(ST_TRUNC);
      clear_parser();
    end
  endfunction

  // Message building helpers.
  function automatic void put(logic [7:0] b, logic last = 1'b0);
    msg_byte_t m;
    m.data = b;
    m.last = last;
    byte_stream.push_back(m);
  endfunction

  function automatic void put_header(logic [15:0] flags, logic [15:0] qd, logic [15:0] an);
    put(8'($urandom)); put(8'($urandom));
    put(flags[15:8]); put(flags[7:0]); put(qd[15:8]); put(qd[7:0]);
    put(an[15:8]); put(an[7:0]);
    repeat (4) put(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_type();
    case ($urandom_range(0, 2))
      0: return TYPE_A;
      1: return TYPE_AAAA;
      default: return TYPE_CNAME;
    endcase
  endfunction

  // A well-formed response with random content, sometimes damaged.
  function automatic void build_random_message();
    int unsigned n_labels, n_ans, len, dlen, cut, start;
    logic [15:0] qt, rt;
    start = byte_stream.size();
    n_ans = $urandom_range(0, 9);
    put_header({$urandom_range(0, 15) == 0 ? 12'($urandom) : 12'($urandom) & 12'hFF0,
                $urandom_range(0, 19) == 0 ? 4'($urandom) : 4'd0},
               $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'd1,
               $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'(n_ans));
    n_labels = $urandom_range(1, 4);
    for (int i = 0; i < n_labels; i++) begin
      len = $urandom_range(1, 12);
      put(8'(len));
      for (int j = 0; j < len; j++) put(8'($urandom));
    end
    put(8'd0);
    qt = $urandom_range(0, 19) == 0 ? 16'($urandom) : pick_type();
    put(qt[15:8]); put(qt[7:0]); put(8'd0); put(8'd1);
    for (int a = 0; a < n_ans; a++) begin
      rt = $urandom_range(0, 29) == 0 ? 16'($urandom) : pick_type();
      dlen = $urandom_range(0, 29) == 0 ? $urandom_range(0, 300) : $urandom_range(0, 16);
      put(8'hC0); put(8'h0C); put(rt[15:8]); put(rt[7:0]); put(8'd0); put(8'd1);
      repeat (4) put(8'($urandom));
      put(dlen[15:8]); put(dlen[7:0]);
      for (int j = 0; j < dlen; j++) put(8'($urandom));
    end
    // Some trailing bytes, or an early end.
    cut = byte_stream.size() - start;
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut);
    while (byte_stream.size() > start + cut) void'(byte_stream.pop_back());
    repeat ($urandom_range(0, 3)) put(8'($urandom));
    byte_stream[byte_stream.size() - 1].last = 1'b1;
  endfunction

  // Directed messages: each row is a header/first-label shape with, where
  // obvious, the status it must close with.
  typedef struct {
    logic [15:0] flags;
    logic [15:0] qd;
    logic [7:0]  first_len;
    logic [15:0] qtype;
    bit          status_known;
    logic [2:0]  status;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{16'h0000, 16'd1, 8'd3,   TYPE_A,     1'b0, ST_OK},
    '{16'hFFFF, 16'd1, 8'd0,   TYPE_A,     1'b1, ST_RCODE},
    '{16'h8180, 16'd0, 8'd0,   TYPE_A,     1'b1, ST_QDCNT},
    '{16'h8180, 16'hFFFF, 8'd0, TYPE_A,    1'b1, ST_QDCNT},
    '{16'h0000, 16'd1, 8'd0,   TYPE_A,     1'b1, ST_NAME},
    '{16'h0000, 16'd1, 8'hC0,  TYPE_A,     1'b1, ST_PTR},
    '{16'h0000, 16'd1, 8'hFF,  TYPE_A,     1'b1, ST_PTR},
    '{16'h0000, 16'd1, 8'd64,  TYPE_A,     1'b1, ST_NAME},
    '{16'h0000, 16'd1, 8'd191, TYPE_A,     1'b1, ST_NAME},
    '{16'h0000, 16'd1, 8'd63,  TYPE_AAAA,  1'b0, ST_OK},
    '{16'h0000, 16'd1, 8'd1,   TYPE_CNAME, 1'b0, ST_OK},
    '{16'h0000, 16'd1, 8'd2,   16'hFFFF,   1'b1, ST_TYPE}
  };

  // Directed stimulus into the byte stream, with one status entry per message.
  status_check_t directed_status[$];

  function automatic void add_status(bit known, logic [2:0] st);
    status_check_t c;
    c.known = known;
    c.status = st;
    directed_status.push_back(c);
  endfunction

  function automatic void build_directed();
    logic [15:0] t;
    int unsigned start;
    foreach (dir_rows[i]) begin
      put_header(dir_rows[i].flags, dir_rows[i].qd, 16'd2);
      put(dir_rows[i].first_len);
      if (dir_rows[i].first_len inside {[1:63]}) begin
        repeat (dir_rows[i].first_len) put(8'($urandom));
        put(8'd0);
        t = dir_rows[i].qtype;
        put(t[15:8]); put(t[7:0]); put(8'd0); put(8'd1);
        // One answer with four data bytes, one with an overlong rdlength.
        put(8'hC0); put(8'h0C); put(8'd0); put(TYPE_A[7:0]); put(8'd0); put(8'd1);
        put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); put(8'd0); put(8'd4);
        repeat (4) put(8'($urandom));
        put(8'hC0); put(8'h0C); put(8'd0); put(TYPE_CNAME[7:0]); put(8'd0); put(8'd1);
        repeat (4) put(8'd0);
        put(8'h01); put(8'h00);
      end
      put(8'h00, 1'b1);
      add_status(dir_rows[i].status_known, dir_rows[i].status);
    end
    // One label more than the parser allows.
    put_header(16'd0, 16'd1, 16'd0);
    repeat (LABEL_LIMIT + 1) begin put(8'd1); put(8'h41); end
    put(8'd0, 1'b1);
    add_status(1'b1, ST_NAME);
    // The longest name that is still accepted, then a CNAME answer whose data
    // runs past the payload bound.
    start = byte_stream.size();
    put_header(16'd0, 16'd1, 16'd1);
    repeat (4) begin put(8'd63); repeat (63) put(8'h7A); end
    put(8'd0); put(8'd0); put(TYPE_A[7:0]); put(8'd0); put(8'd1);
    put(8'hC0); put(8'h0C); put(8'd0); put(TYPE_CNAME[7:0]); put(8'd0); put(8'd1);
    repeat (4) put(8'($urandom)); put(8'd0); put(8'd255);
    repeat (255) put(8'($urandom));
    while (byte_stream.size() > start + PAYLOAD_LIMIT + 1) void'(byte_stream.pop_back());
    put(8'd0, 1'b1);
    add_status(1'b1, ST_TRUNC);
    // A single answer with no data, closing cleanly; a spare byte follows.
    put_header(16'd0, 16'd1, 16'd1);
    put(8'd1); put(8'h61); put(8'd0); put(8'd0); put(TYPE_A[7:0]); put(8'd0); put(8'd1);
    put(8'hC0); put(8'h0C); put(8'd0); put(TYPE_A[7:0]); put(8'd0); put(8'd1);
    repeat (4) put(8'd0); put(8'd0); put(8'd0);
    put(8'd0, 1'b1);
    add_status(1'b1, ST_OK);
  endfunction

  // Sender: offers bytes, idling at random outside the quiet spell.
  initial begin
    int unsigned sent;
    clear_parser();
    build_directed();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    sent = 0;
    while (byte_stream.size() > 0 || sent < ITEM_TARGET) begin
      if (byte_stream.size() == 0) begin
        build_random_message();
        continue;
      end
      quiet_spell <= (sent > 300 && sent < 700);
      if (!quiet_spell && $urandom_range(0, 99) < 13) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        continue;
      end
      in_valid_i <= 1'b1;
      payload_byte_i <= byte_stream[0].data;
      message_end_i <= byte_stream[0].last;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      predict_byte(byte_stream[0].data, byte_stream[0].last);
      void'(byte_stream.pop_front());
      sent++;
    end
    in_valid_i <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("dns_response_parser_test: done, clean");
    else $display("dns_response_parser_test: done, errors");
    $finish;
  end

  // Receiver readiness, with one long hold-off.
  initial begin
    int unsigned held;
    held = 0;
    @(posedge rst_ni);
    repeat (200) @(posedge clk_i);
    rx_hold = 1'b1;
    while (held < 300) begin
      @(posedge clk_i);
      held++;
    end
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && (quiet_spell || $urandom_range(0, 99) >= 13);
  end

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_r;
    status_check_t chk;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", result_kind_o));
      end else begin
        exp_r = expected_results.pop_front();
        if (result_kind_o !== exp_r.kind) report_mismatch("result_kind");
        if (byte_value_o !== exp_r.byte_value) report_mismatch("byte_value");
        if (record_type_o !== exp_r.record_type) report_mismatch("record_type");
        if (time_to_live_o !== exp_r.ttl) report_mismatch("time_to_live");
        if (data_length_o !== exp_r.data_length) report_mismatch("data_length");
        if (answer_index_o !== exp_r.answer_index) report_mismatch("answer_index");
        if (response_code_o !== exp_r.response_code) report_mismatch("response_code");
        if (answer_total_o !== exp_r.answer_total) report_mismatch("answer_total");
        if (parse_status_o !== exp_r.status) report_mismatch("parse_status");
        if (last_result_o !== exp_r.last) report_mismatch("last_result");
        // Statuses of the directed messages are also checked where known outright.
        if (exp_r.kind == KIND_STATUS && directed_status.size() > 0) begin
          chk = directed_status.pop_front();
          if (chk.known && parse_status_o !== chk.status)
            report_mismatch("directed status");
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dns_response_parser_test: done, errors");
      $finish;
    end
  end

endmodule
